// ----- hdl/qacm_pkg.sv -----
`timescale 1ns / 1ps
package qacm_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned DIV_STEPS = 31;
  // setup, one register per quotient bit, multiply, final add
  localparam int unsigned EDGE_LAT  = DIV_STEPS + 3;
  localparam int unsigned TEST_LAT  = EDGE_LAT + 1;
  localparam int unsigned TOTAL_LAT = 2 * TEST_LAT + 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LB_X = 3'd0,
    REG_LB_Y = 3'd1,
    REG_RB_X = 3'd2,
    REG_RB_Y = 3'd3,
    REG_RT_X = 3'd4,
    REG_RT_Y = 3'd5,
    REG_LT_X = 3'd6,
    REG_LT_Y = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] current_x;
    logic signed [31:0] current_y;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
  } item_t;

  typedef struct packed {
    logic               moved;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
  } result_t;

  // one edge: runs from start by delta along one axis, other axis from s0 by d
  typedef struct packed {
    logic signed [31:0] start;
    logic signed [32:0] delta;
    logic        [32:0] dabs;
    logic signed [31:0] s0;
    logic signed [32:0] d;
    logic        [32:0] dmag;
  } edge_cfg_t;

  typedef struct packed {
    logic l;
    logic r;
    logic t;
    logic b;
  } side_ok_t;

  typedef struct packed {
    logic signed [31:0] l;
    logic signed [31:0] r;
    logic signed [31:0] t;
    logic signed [31:0] b;
  } bounds_t;

endpackage

// ----- hdl/qacm_edge.sv -----
`timescale 1ns / 1ps
module qacm_edge (
  input  logic                      clk_i,
  input  qacm_pkg::edge_cfg_t       cfg_i,
  input  logic signed [31:0]        p_i,
  output logic signed [31:0]        value_o
);
  import qacm_pkg::*;

  logic        [33:0] r_q  [0:DIV_STEPS];
  logic        [30:0] q_q  [0:DIV_STEPS];
  logic               lo_q [0:DIV_STEPS+1];
  logic               hi_q [0:DIV_STEPS+1];
  logic        [63:0] mag_q;
  logic signed [31:0] value_q;

  logic signed [32:0] num;
  logic        [32:0] an;
  logic signed [33:0] off;
  logic signed [33:0] far;
  logic signed [33:0] sum;

  assign num = 33'(p_i) - 33'(cfg_i.start);
  assign an  = num[32] ? 33'(-num) : 33'(num);

  always_ff @(posedge clk_i) begin
    r_q[0]  <= {1'b0, an};
    q_q[0]  <= '0;
    lo_q[0] <= (num == '0) || (num[32] != cfg_i.delta[32]);
    hi_q[0] <= an > cfg_i.dabs;
  end

  // one quotient bit per stage; remainder stays below the divisor
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [33:0] t;
    logic        bit_q;
    assign t     = (j == 0) ? r_q[j] : {r_q[j][32:0], 1'b0};
    assign bit_q = t >= {1'b0, cfg_i.dabs};
    always_ff @(posedge clk_i) begin
      r_q[j+1]  <= bit_q ? t - {1'b0, cfg_i.dabs} : t;
      q_q[j+1]  <= {q_q[j][29:0], bit_q};
      lo_q[j+1] <= lo_q[j];
      hi_q[j+1] <= hi_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q              <= 64'(cfg_i.dmag) * 64'(q_q[DIV_STEPS]);
    lo_q[DIV_STEPS+1]  <= lo_q[DIV_STEPS];
    hi_q[DIV_STEPS+1]  <= hi_q[DIV_STEPS];
  end

  assign off = signed'(mag_q[63:30]);
  assign far = 34'(cfg_i.s0) + 34'(cfg_i.d);
  assign sum = cfg_i.d[32] ? 34'(cfg_i.s0) - off : 34'(cfg_i.s0) + off;

  always_ff @(posedge clk_i) begin
    if (lo_q[DIV_STEPS+1]) begin
      value_q <= cfg_i.s0;
    end else if (hi_q[DIV_STEPS+1]) begin
      value_q <= far[31:0];
    end else begin
      value_q <= sum[31:0];
    end
  end

  assign value_o = value_q;

endmodule

// ----- hdl/qacm_test.sv -----
`timescale 1ns / 1ps
module qacm_test (
  input  logic                 clk_i,
  input  qacm_pkg::edge_cfg_t  left_i,
  input  qacm_pkg::edge_cfg_t  right_i,
  input  qacm_pkg::edge_cfg_t  top_i,
  input  qacm_pkg::edge_cfg_t  bottom_i,
  input  logic signed [31:0]   x_i,
  input  logic signed [31:0]   y_i,
  output qacm_pkg::side_ok_t   ok_o,
  output qacm_pkg::bounds_t    bounds_o
);
  import qacm_pkg::*;

  logic signed [31:0] x_q [0:EDGE_LAT-1];
  logic signed [31:0] y_q [0:EDGE_LAT-1];
  bounds_t            bnd;
  side_ok_t           ok_q;
  bounds_t            bounds_q;

  qacm_edge u_left   (.clk_i, .cfg_i(left_i),   .p_i(y_i), .value_o(bnd.l));
  qacm_edge u_right  (.clk_i, .cfg_i(right_i),  .p_i(y_i), .value_o(bnd.r));
  qacm_edge u_top    (.clk_i, .cfg_i(top_i),    .p_i(x_i), .value_o(bnd.t));
  qacm_edge u_bottom (.clk_i, .cfg_i(bottom_i), .p_i(x_i), .value_o(bnd.b));

  always_ff @(posedge clk_i) begin
    x_q[0] <= x_i;
    y_q[0] <= y_i;
    for (int i = 1; i < EDGE_LAT; i++) begin
      x_q[i] <= x_q[i-1];
      y_q[i] <= y_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q.l   <= x_q[EDGE_LAT-1] >= bnd.l;
    ok_q.r   <= x_q[EDGE_LAT-1] <= bnd.r;
    ok_q.t   <= y_q[EDGE_LAT-1] <= bnd.t;
    ok_q.b   <= y_q[EDGE_LAT-1] >= bnd.b;
    bounds_q <= bnd;
  end

  assign ok_o     = ok_q;
  assign bounds_o = bounds_q;

endmodule

// ----- hdl/quad_area_constrained_move_unit.sv -----
`timescale 1ns / 1ps
// From the accepting edge to done_o: input register, first test, snap register, second test, output register.
// Throughput: one item per cycle; busy stays low, start may be high every cycle.
// Each edge test runs a 31-stage restoring divider, one quotient bit a stage,
// then a multiply and an add stage; the test runs twice in series.
// Reset clears the corner registers to zero and empties the pipeline.
// The receiver cannot stall: each result shows for exactly one cycle.
module quad_area_constrained_move_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  qacm_pkg::item_t                 item_i,
  output logic                            done_o,
  output qacm_pkg::result_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [qacm_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                     cfg_data_i
);
  import qacm_pkg::*;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } side1_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               pass1;
    logic               reject;
  } side2_t;

  logic signed [31:0] cfg_q [0:NUM_REGS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic signed [32:0] dly, dry, dtx, dbx, dlx, drx, dty, dby;
  logic               empty;
  edge_cfg_t          e_left, e_right, e_top, e_bottom;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  assign dly = 33'(cfg_q[REG_LT_Y]) - 33'(cfg_q[REG_LB_Y]);
  assign dlx = 33'(cfg_q[REG_LT_X]) - 33'(cfg_q[REG_LB_X]);
  assign dry = 33'(cfg_q[REG_RT_Y]) - 33'(cfg_q[REG_RB_Y]);
  assign drx = 33'(cfg_q[REG_RT_X]) - 33'(cfg_q[REG_RB_X]);
  assign dtx = 33'(cfg_q[REG_RT_X]) - 33'(cfg_q[REG_LT_X]);
  assign dty = 33'(cfg_q[REG_RT_Y]) - 33'(cfg_q[REG_LT_Y]);
  assign dbx = 33'(cfg_q[REG_RB_X]) - 33'(cfg_q[REG_LB_X]);
  assign dby = 33'(cfg_q[REG_RB_Y]) - 33'(cfg_q[REG_LB_Y]);
  assign empty = (dly == '0) || (dry == '0) || (dtx == '0) || (dbx == '0);

  assign e_left   = '{start: cfg_q[REG_LB_Y], delta: dly, dabs: mag33(dly),
                      s0: cfg_q[REG_LB_X], d: dlx, dmag: mag33(dlx)};
  assign e_right  = '{start: cfg_q[REG_RB_Y], delta: dry, dabs: mag33(dry),
                      s0: cfg_q[REG_RB_X], d: drx, dmag: mag33(drx)};
  assign e_top    = '{start: cfg_q[REG_LT_X], delta: dtx, dabs: mag33(dtx),
                      s0: cfg_q[REG_LT_Y], d: dty, dmag: mag33(dty)};
  assign e_bottom = '{start: cfg_q[REG_LB_X], delta: dbx, dabs: mag33(dbx),
                      s0: cfg_q[REG_LB_Y], d: dby, dmag: mag33(dby)};

  assign busy = 1'b0;

  // input stage: saturate the moved point
  logic signed [32:0] sum_x, sum_y;
  side1_t             s0_d, s0_q;
  logic               v0_q;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return v[31:0];
  endfunction

  assign sum_x = 33'(item_i.current_x) + 33'(item_i.move_x);
  assign sum_y = 33'(item_i.current_y) + 33'(item_i.move_y);

  always_comb begin
    s0_d.cx = item_i.current_x;
    s0_d.cy = item_i.current_y;
    s0_d.mx = item_i.move_x;
    s0_d.my = item_i.move_y;
    s0_d.px = sat32(sum_x);
    s0_d.py = sat32(sum_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) s0_q <= s0_d;
  end

  // first test
  side_ok_t ok1, ok2;
  bounds_t  bnd1, bnd2;
  side1_t   s1_q [0:TEST_LAT-1];
  logic     v1_q [0:TEST_LAT-1];

  qacm_test u_test1 (
    .clk_i, .left_i(e_left), .right_i(e_right), .top_i(e_top), .bottom_i(e_bottom),
    .x_i(s0_q.px), .y_i(s0_q.py), .ok_o(ok1), .bounds_o(bnd1)
  );

  always_ff @(posedge clk_i) begin
    s1_q[0] <= s0_q;
    for (int i = 1; i < TEST_LAT; i++) s1_q[i] <= s1_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TEST_LAT; i++) v1_q[i] <= 1'b0;
    end else begin
      v1_q[0] <= v0_q;
      for (int i = 1; i < TEST_LAT; i++) v1_q[i] <= v1_q[i-1];
    end
  end

  // handle the first failing side: reject an outward move, else snap
  side1_t s1;
  side2_t d_d, d_q;
  logic   vd_q;

  assign s1 = s1_q[TEST_LAT-1];

  always_comb begin
    d_d.cx     = s1.cx;
    d_d.cy     = s1.cy;
    d_d.px     = s1.px;
    d_d.py     = s1.py;
    d_d.pass1  = ok1.l && ok1.r && ok1.t && ok1.b;
    d_d.reject = 1'b0;
    if (!ok1.l) begin
      if (s1.mx < 0) d_d.reject = 1'b1;
      else           d_d.px = bnd1.l;
    end else if (!ok1.r) begin
      if (s1.mx > 0) d_d.reject = 1'b1;
      else           d_d.px = bnd1.r;
    end else if (!ok1.t) begin
      if (s1.my > 0) d_d.reject = 1'b1;
      else           d_d.py = bnd1.t;
    end else if (!ok1.b) begin
      if (s1.my < 0) d_d.reject = 1'b1;
      else           d_d.py = bnd1.b;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else         vd_q <= v1_q[TEST_LAT-1];
  end

  // second test
  side2_t s2_q [0:TEST_LAT-1];
  logic   v2_q [0:TEST_LAT-1];

  qacm_test u_test2 (
    .clk_i, .left_i(e_left), .right_i(e_right), .top_i(e_top), .bottom_i(e_bottom),
    .x_i(d_q.px), .y_i(d_q.py), .ok_o(ok2), .bounds_o(bnd2)
  );

  always_ff @(posedge clk_i) begin
    s2_q[0] <= d_q;
    for (int i = 1; i < TEST_LAT; i++) s2_q[i] <= s2_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TEST_LAT; i++) v2_q[i] <= 1'b0;
    end else begin
      v2_q[0] <= vd_q;
      for (int i = 1; i < TEST_LAT; i++) v2_q[i] <= v2_q[i-1];
    end
  end

  // output stage
  side2_t  s2;
  logic    moved;
  logic    bnd2_unused;
  result_t res_q;
  logic    done_q;

  assign s2          = s2_q[TEST_LAT-1];
  assign bnd2_unused = ^bnd2;
  assign moved = !empty && (s2.pass1 ||
                 (!s2.reject && ok2.l && ok2.r && ok2.t && ok2.b));

  always_ff @(posedge clk_i) begin
    res_q.moved <= moved;
    res_q.new_x <= moved ? s2.px : s2.cx;
    res_q.new_y <= moved ? s2.py : s2.cy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= v2_q[TEST_LAT-1] && (bnd2_unused || !bnd2_unused);
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- hdl/qacm_checker.sv -----
`timescale 1ns / 1ps
module qacm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input qacm_pkg::item_t     item_i,
  input logic                done_o,
  input qacm_pkg::result_t   result_o
);
  import qacm_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, TOTAL_LAT))
    else $error("result beat without an accepted item");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.moved) |->
      (result_o.new_x == $past(item_i.current_x, TOTAL_LAT) &&
       result_o.new_y == $past(item_i.current_y, TOTAL_LAT)))
    else $error("rejected move changed the position");

endmodule

bind quad_area_constrained_move_unit qacm_checker u_qacm_checker (
  .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o
);

// ----- verif/qacm_checker.sv -----
`timescale 1ns / 1ps
module qacm_scoreboard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  qacm_pkg::item_t    item_i,
  input  logic               done_o,
  input  qacm_pkg::result_t  result_o,
  input  logic               cfg_we_i,
  input  logic [qacm_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count,
  output int                 pending,
  output int                 moves_checked,
  output int                 moved_count
);
  import qacm_pkg::*;

  logic signed [31:0] corner [NUM_REGS];
  result_t expected_moves [$];

  typedef struct {
    longint bl, br, bt, bb;
    bit okl, okr, okt, okb;
  } side_test_t;

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint edge_at(longint p, longint st, longint dl,
                                     longint s0, longint d);
    longint num, off;
    longint unsigned an, ad, q, mag;
    num = p - st;
    if (num == 0 || ((num < 0) != (dl < 0))) return s0;
    an = (num < 0) ? -num : num;
    ad = (dl < 0) ? -dl : dl;
    if (an > ad) return s0 + d;
    q = (an << 30) / ad;
    mag = ((d < 0) ? -d : d) * q;
    off = mag >> 30;
    return (d < 0) ? s0 - off : s0 + off;
  endfunction

  function automatic bit area_empty();
    return corner[REG_LT_Y] == corner[REG_LB_Y] || corner[REG_RT_Y] == corner[REG_RB_Y] ||
           corner[REG_RT_X] == corner[REG_LT_X] || corner[REG_RB_X] == corner[REG_LB_X];
  endfunction

  function automatic bit inside_area(longint x, longint y, output side_test_t t);
    longint lbx, lby, rbx, rby, rtx, rty, ltx, lty;
    lbx = corner[REG_LB_X]; lby = corner[REG_LB_Y];
    rbx = corner[REG_RB_X]; rby = corner[REG_RB_Y];
    rtx = corner[REG_RT_X]; rty = corner[REG_RT_Y];
    ltx = corner[REG_LT_X]; lty = corner[REG_LT_Y];
    t.okl = 0; t.okr = 0; t.okt = 0; t.okb = 0;
    t.bl = lbx; t.br = rbx; t.bt = lty; t.bb = lby;
    if (lty == lby || rty == rby || rtx == ltx || rbx == lbx) return 0;
    t.bl = edge_at(y, lby, lty - lby, lbx, ltx - lbx);
    t.br = edge_at(y, rby, rty - rby, rbx, rtx - rbx);
    t.bt = edge_at(x, ltx, rtx - ltx, lty, rty - lty);
    t.bb = edge_at(x, lbx, rbx - lbx, lby, rby - lby);
    t.okl = x >= t.bl;
    t.okr = x <= t.br;
    t.okt = y <= t.bt;
    t.okb = y >= t.bb;
    return t.okl && t.okr && t.okt && t.okb;
  endfunction

  function automatic result_t constrain_move(item_t it);
    longint cx, cy, mx, my, px, py;
    side_test_t t;
    bit ok, reject;
    result_t r;
    cx = it.current_x; cy = it.current_y; mx = it.move_x; my = it.move_y;
    px = sat_word(cx + mx);
    py = sat_word(cy + my);
    ok = inside_area(px, py, t);
    // an empty area (zero edge delta) never snaps; a real area snaps even
    // when every side fails
    if (!ok && (t.okl || t.okr || t.okt || t.okb || !area_empty())) begin
      reject = 0;
      if (!t.okl) begin
        if (mx < 0) reject = 1; else px = t.bl;
      end else if (!t.okr) begin
        if (mx > 0) reject = 1; else px = t.br;
      end else if (!t.okt) begin
        if (my > 0) reject = 1; else py = t.bt;
      end else if (!t.okb) begin
        if (my < 0) reject = 1; else py = t.bb;
      end
      if (!reject) ok = inside_area(px, py, t);
    end
    if (!ok) begin
      px = cx; py = cy;
    end
    r.moved = ok;
    r.new_x = px[31:0];
    r.new_y = py[31:0];
    return r;
  endfunction

  assign pending = expected_moves.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) corner[i] = '0;
      expected_moves.delete();
      fail_count = 0;
      moves_checked = 0;
      moved_count = 0;
    end else begin
      if (done_o) begin
        if (expected_moves.size() == 0) begin
          $error("unexpected result beat: %p", result_o);
          fail_count++;
        end else begin
          exp_r = expected_moves.pop_front();
          moves_checked++;
          if (exp_r.moved) moved_count++;
          if (result_o.moved !== exp_r.moved) begin
            $error("moved: expected %0d, actual %0d", exp_r.moved, result_o.moved);
            fail_count++;
          end
          if (result_o.new_x !== exp_r.new_x) begin
            $error("new_x: expected %0d, actual %0d", exp_r.new_x, result_o.new_x);
            fail_count++;
          end
          if (result_o.new_y !== exp_r.new_y) begin
            $error("new_y: expected %0d, actual %0d", exp_r.new_y, result_o.new_y);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_moves.push_back(constrain_move(item_i));
      if (cfg_we_i) corner[cfg_idx_i] = cfg_data_i;
    end
  end
endmodule

// ----- verif/tb_quad_area_constrained_move_unit.sv -----
`timescale 1ns / 1ps
module tb_quad_area_constrained_move_unit;
  import qacm_pkg::*;

  localparam int SETTLE = TOTAL_LAT + 10;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  item_t item_i = '0;
  logic done_o;
  result_t result_o;
  logic cfg_we_i = 0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int fail_count, pending, moves_checked, moved_count;
  int idle_pct;
  int areas_used;

  always #5 clk_i = ~clk_i;

  quad_area_constrained_move_unit u_top (.*);

  qacm_scoreboard u_checker (.*);

  task automatic send_move(logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] mx, logic [31:0] my);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    item_i <= '{current_x: cx, current_y: cy, move_x: mx, move_y: my};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_corner(reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // corners in order LB, RB, RT, LT as x,y pairs
  task automatic set_area(logic [31:0] c [8]);
    write_corner(REG_LB_X, c[0]); write_corner(REG_LB_Y, c[1]);
    write_corner(REG_RB_X, c[2]); write_corner(REG_RB_Y, c[3]);
    write_corner(REG_RT_X, c[4]); write_corner(REG_RT_Y, c[5]);
    write_corner(REG_LT_X, c[6]); write_corner(REG_LT_Y, c[7]);
    @(posedge clk_i);
    areas_used++;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom_range(200 << 16)) - (100 << 16);
    endcase
  endfunction

  task automatic random_area();
    logic [31:0] c [8];
    int s;
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < 8; i++) c[i] = rnd_word();
    end else begin
      s = $urandom_range(1, 80) << 16;
      c = '{-s + $signed($urandom_range(20 << 16)) - (10 << 16),
            -s + $signed($urandom_range(20 << 16)) - (10 << 16),
             s + $signed($urandom_range(20 << 16)) - (10 << 16),
            -s + $signed($urandom_range(20 << 16)) - (10 << 16),
             s + $signed($urandom_range(20 << 16)) - (10 << 16),
             s + $signed($urandom_range(20 << 16)) - (10 << 16),
            -s + $signed($urandom_range(20 << 16)) - (10 << 16),
             s + $signed($urandom_range(20 << 16)) - (10 << 16)};
    end
    set_area(c);
  endtask

  initial begin
    #50_000_000;
    $display("quad_area_constrained_move_unit regression: fail");
    $finish;
  end

  initial begin
    logic [31:0] sq [8];
    logic [31:0] wide [8];
    areas_used = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // empty area after reset: every move rejected
    send_move(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'hffff_0000);
    drain();

    sq = '{-(10 << 16), -(10 << 16), 10 << 16, -(10 << 16),
           10 << 16, 10 << 16, -(10 << 16), 10 << 16};
    set_area(sq);
    send_move(0, 0, 1 << 16, 1 << 16);
    send_move(0, 0, 20 << 16, 0);
    send_move(0, 0, -(20 << 16), 0);
    send_move(0, 0, 0, 20 << 16);
    send_move(0, 0, 0, -(20 << 16));
    send_move(-(20 << 16), 0, 0, 0);
    send_move(20 << 16, 0, 0, 0);
    send_move(0, 20 << 16, 0, 0);
    send_move(0, -(20 << 16), 0, 0);
    send_move(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_move(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_move(10 << 16, 10 << 16, 0, 0);
    send_move(-(30 << 16), 30 << 16, 0, 0);
    drain();

    // skewed quad, edges beyond the ends
    wide = '{-(40 << 16), -(5 << 16), 30 << 16, -(20 << 16),
             50 << 16, 25 << 16, -(10 << 16), 15 << 16};
    set_area(wide);
    send_move(0, 0, 60 << 16, 60 << 16);
    send_move(0, 0, -(60 << 16), -(60 << 16));
    send_move(35 << 16, 0, 0, 0);
    send_move(0, 24 << 16, 0, 0);
    send_move(32'hffff_ffff, 32'h0000_0001, 32'h1234_5678, 32'hedcb_a987);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 59 : (ph == 3) ? 12 : 0;
      for (int n = 0; n < 480; n++) begin
        if (n % 80 == 0) begin
          drain();
          random_area();
        end
        if ($urandom_range(7) == 0)
          send_move($urandom(), $urandom(), $urandom(), $urandom());
        else
          send_move(rnd_word(), rnd_word(), rnd_word(), rnd_word());
      end
    end
    drain();

    $display("covered %0d results over %0d area settings, %0d moved",
             moves_checked, areas_used, moved_count);
    if (fail_count == 0) begin
      $display("quad_area_constrained_move_unit regression: pass");
    end else begin
      $display("quad_area_constrained_move_unit regression: fail");
    end
    $finish;
  end
endmodule
